FILE: hw/rtl/vnorm_pkg.sv
// Shared widths and beat types for the 3-D vector normalizer.
`timescale 1ns / 1ps
`default_nettype none
package vnorm_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int OUT_WIDTH  = 16;
    localparam int FRAC_SHIFT = 14;
    // squares of |c| <= 2^(W-1), three of them
    localparam int ABS_WIDTH  = COMP_WIDTH;
    localparam int SUM_WIDTH  = 2 * COMP_WIDTH + 1;
    localparam int ROOT_WIDTH = (SUM_WIDTH + 1) / 2;
    localparam int SQRT_STEPS = ROOT_WIDTH;
    // dividend |c| << 14, quotient fits in FRAC_SHIFT+1 bits
    localparam int DIVD_WIDTH = ABS_WIDTH + FRAC_SHIFT;
    localparam int QUO_WIDTH  = FRAC_SHIFT + 1;
    localparam int IN_BYTES   = (3 * COMP_WIDTH + 7) / 8;
    localparam int IN_TDATA_W = IN_BYTES * 8;
    localparam int OUT_TDATA_W = 4 * OUT_WIDTH;

    typedef struct packed {
        logic [ABS_WIDTH-1:0] mag_x;
        logic [ABS_WIDTH-1:0] mag_y;
        logic [ABS_WIDTH-1:0] mag_z;
        logic                 neg_x;
        logic                 neg_y;
        logic                 neg_z;
    } vec_abs_t;

endpackage
`default_nettype wire

FILE: hw/rtl/vnorm_sqrt.sv
// Pipelined restoring square root, one result bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module vnorm_sqrt
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic [vnorm_pkg::SUM_WIDTH-1:0]    radicand,
    input  wire vnorm_pkg::vec_abs_t                in_side,
    output logic                                    out_valid,
    output logic [vnorm_pkg::ROOT_WIDTH-1:0]        root,
    output vnorm_pkg::vec_abs_t                     out_side
);
    import vnorm_pkg::*;

    localparam int RW = 2 * ROOT_WIDTH;

    logic [SQRT_STEPS-1:0]   vld_reg;
    logic [RW-1:0]           rem_reg  [SQRT_STEPS];
    logic [RW-1:0]           num_reg  [SQRT_STEPS];
    logic [ROOT_WIDTH-1:0]   res_reg  [SQRT_STEPS];
    vec_abs_t                side_reg [SQRT_STEPS];

    genvar s;
    generate
        for (s = 0; s < SQRT_STEPS; s++)
        begin : g_stage
            logic [RW-1:0]         rem_in;
            logic [RW-1:0]         num_in;
            logic [ROOT_WIDTH-1:0] res_in;
            vec_abs_t              side_in;
            logic                  vld_in;
            logic [RW-1:0]         rem_sh;
            logic [RW-1:0]         trial;
            logic [RW-1:0]         rem_next;
            logic [ROOT_WIDTH-1:0] res_next;

            if (s == 0)
            begin : g_first
                assign rem_in  = '0;
                assign num_in  = RW'(radicand);
                assign res_in  = '0;
                assign side_in = in_side;
                assign vld_in  = in_valid;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[s-1];
                assign num_in  = num_reg[s-1];
                assign res_in  = res_reg[s-1];
                assign side_in = side_reg[s-1];
                assign vld_in  = vld_reg[s-1];
            end

            always_comb
            begin
                rem_sh = {rem_in[RW-3:0], num_in[RW-1:RW-2]};
                trial  = RW'({res_in, 2'b01});
                if (rem_sh >= trial)
                begin
                    rem_next = rem_sh - trial;
                    res_next = {res_in[ROOT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    res_next = {res_in[ROOT_WIDTH-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[s] <= 1'b0;
                else if (en)
                    vld_reg[s] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_next;
                    num_reg[s]  <= {num_in[RW-3:0], 2'b00};
                    res_reg[s]  <= res_next;
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign root      = res_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule
`default_nettype wire

FILE: hw/rtl/vnorm_div.sv
// Pipelined restoring divider: (mag << 14) / norm, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vnorm_div
(
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [vnorm_pkg::ABS_WIDTH-1:0]    mag,
    input  wire logic [vnorm_pkg::ROOT_WIDTH-1:0]   divisor,
    output logic [vnorm_pkg::QUO_WIDTH-1:0]         quotient
);
    import vnorm_pkg::*;

    // remainder stays below divisor, one extra bit for the shift
    localparam int REM_W = ROOT_WIDTH + 1;

    logic [REM_W-1:0]      rem_reg [QUO_WIDTH];
    logic [DIVD_WIDTH-1:0] num_reg [QUO_WIDTH];
    logic [ROOT_WIDTH-1:0] dvs_reg [QUO_WIDTH];
    logic [QUO_WIDTH-1:0]  quo_reg [QUO_WIDTH];

    // the top ABS_WIDTH-1 quotient bits are zero since |c| <= norm;
    // the first stage starts from the partial remainder of those bits
    logic [REM_W-1:0]      rem_seed;
    logic [DIVD_WIDTH-1:0] num_seed;
    assign rem_seed = REM_W'(mag[ABS_WIDTH-1:1]);
    assign num_seed = {mag[0], FRAC_SHIFT'(0), (ABS_WIDTH-1)'(0)};

    genvar s;
    generate
        for (s = 0; s < QUO_WIDTH; s++)
        begin : g_stage
            logic [REM_W-1:0]      rem_in;
            logic [DIVD_WIDTH-1:0] num_in;
            logic [ROOT_WIDTH-1:0] dvs_in;
            logic [QUO_WIDTH-1:0]  quo_in;
            logic [REM_W:0]        rem_sh;
            logic [REM_W:0]        diff;

            if (s == 0)
            begin : g_first
                assign rem_in = rem_seed;
                assign num_in = num_seed;
                assign dvs_in = divisor;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign num_in = num_reg[s-1];
                assign dvs_in = dvs_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            assign rem_sh = {rem_in, num_in[DIVD_WIDTH-1]};
            assign diff   = rem_sh - (REM_W+1)'(dvs_in);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!diff[REM_W])
                    begin
                        rem_reg[s] <= diff[REM_W-1:0];
                        quo_reg[s] <= {quo_in[QUO_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s] <= rem_sh[REM_W-1:0];
                        quo_reg[s] <= {quo_in[QUO_WIDTH-2:0], 1'b0};
                    end
                    num_reg[s] <= {num_in[DIVD_WIDTH-2:0], 1'b0};
                    dvs_reg[s] <= dvs_in;
                end
            end
        end
    endgenerate

    assign quotient = quo_reg[QUO_WIDTH-1];

endmodule
`default_nettype wire

FILE: hw/rtl/vector_normalize_3d.sv
// Top level: 3-D vector norm and unit vector, fully pipelined.
//
//  channel | dir | tdata (low bit up)                        | tuser
//  s_axis  | in  | comp_x, comp_y, comp_z (Q8.8)             | -
//  m_axis  | out | unit_x, unit_y, unit_z (Q1.14), magnitude | zero_vector
//
// One beat per cycle sustained while the output is not stalled. The pipe is the
// square stage, the sum stage, one stage per root bit in the square root, one
// per quotient bit in the three dividers, and the output register. The whole
// pipe advances only when the output register is free or being taken; a stall
// freezes every stage. Reset clears valid bits.
`timescale 1ns / 1ps
`default_nettype none
module vector_normalize_3d
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // comp_x, comp_y, comp_z
    input  wire logic [vnorm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // unit_x, unit_y, unit_z, magnitude
    output logic [vnorm_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    // zero_vector
    output logic                                        m_axis_tuser
);
    import vnorm_pkg::*;

    logic en;
    logic out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic out_zero_reg;

    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---- stage 1: magnitudes and squares
    logic signed [COMP_WIDTH-1:0] cx, cy, cz;
    assign cx = s_axis_tdata[COMP_WIDTH-1:0];
    assign cy = s_axis_tdata[2*COMP_WIDTH-1:COMP_WIDTH];
    assign cz = s_axis_tdata[3*COMP_WIDTH-1:2*COMP_WIDTH];

    vec_abs_t abs_next;
    always_comb
    begin
        abs_next.neg_x = cx[COMP_WIDTH-1];
        abs_next.neg_y = cy[COMP_WIDTH-1];
        abs_next.neg_z = cz[COMP_WIDTH-1];
        abs_next.mag_x = cx[COMP_WIDTH-1] ? ABS_WIDTH'(-cx) : ABS_WIDTH'(cx);
        abs_next.mag_y = cy[COMP_WIDTH-1] ? ABS_WIDTH'(-cy) : ABS_WIDTH'(cy);
        abs_next.mag_z = cz[COMP_WIDTH-1] ? ABS_WIDTH'(-cz) : ABS_WIDTH'(cz);
    end

    logic                        s1_vld_reg;
    vec_abs_t                    s1_abs_reg;
    logic [2*ABS_WIDTH-1:0]      sq_x_reg, sq_y_reg, sq_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_abs_reg <= abs_next;
            sq_x_reg   <= abs_next.mag_x * abs_next.mag_x;
            sq_y_reg   <= abs_next.mag_y * abs_next.mag_y;
            sq_z_reg   <= abs_next.mag_z * abs_next.mag_z;
        end
    end

    // ---- stage 2: sum of squares
    logic                  s2_vld_reg;
    vec_abs_t              s2_abs_reg;
    logic [SUM_WIDTH-1:0]  sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_abs_reg <= s1_abs_reg;
            sum_reg    <= SUM_WIDTH'(sq_x_reg) + SUM_WIDTH'(sq_y_reg)
                        + SUM_WIDTH'(sq_z_reg);
        end
    end

    // ---- square root
    logic                  rt_vld;
    logic [ROOT_WIDTH-1:0] rt_root;
    vec_abs_t              rt_abs;

    vnorm_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_vld_reg),
        .radicand  (sum_reg),
        .in_side   (s2_abs_reg),
        .out_valid (rt_vld),
        .root      (rt_root),
        .out_side  (rt_abs)
    );

    // ---- three dividers; sideband delayed alongside
    logic [QUO_WIDTH-1:0] q_x, q_y, q_z;

    vnorm_div u_div_x (.clk(clk), .en(en), .mag(rt_abs.mag_x), .divisor(rt_root),
                       .quotient(q_x));
    vnorm_div u_div_y (.clk(clk), .en(en), .mag(rt_abs.mag_y), .divisor(rt_root),
                       .quotient(q_y));
    vnorm_div u_div_z (.clk(clk), .en(en), .mag(rt_abs.mag_z), .divisor(rt_root),
                       .quotient(q_z));

    logic [QUO_WIDTH-1:0]  dl_vld_reg;
    logic [2:0]            dl_neg_reg  [QUO_WIDTH];
    logic [ROOT_WIDTH-1:0] dl_root_reg [QUO_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dl_vld_reg <= '0;
        else if (en)
            dl_vld_reg <= {dl_vld_reg[QUO_WIDTH-2:0], rt_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_neg_reg[0]  <= {rt_abs.neg_z, rt_abs.neg_y, rt_abs.neg_x};
            dl_root_reg[0] <= rt_root;
            for (int i = 1; i < QUO_WIDTH; i++)
            begin
                dl_neg_reg[i]  <= dl_neg_reg[i-1];
                dl_root_reg[i] <= dl_root_reg[i-1];
            end
        end
    end

    // ---- output register: sign restore, zero vector override
    logic [2:0]            f_neg;
    logic [ROOT_WIDTH-1:0] f_root;
    logic                  f_zero;
    logic [OUT_WIDTH-1:0]  ux, uy, uz;

    assign f_neg  = dl_neg_reg[QUO_WIDTH-1];
    assign f_root = dl_root_reg[QUO_WIDTH-1];
    assign f_zero = (f_root == '0);

    always_comb
    begin
        ux = OUT_WIDTH'(q_x);
        uy = OUT_WIDTH'(q_y);
        uz = OUT_WIDTH'(q_z);
        if (f_neg[0]) ux = -ux;
        if (f_neg[1]) uy = -uy;
        if (f_neg[2]) uz = -uz;
        if (f_zero)
        begin
            ux = '0;
            uy = '0;
            uz = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dl_vld_reg[QUO_WIDTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {OUT_WIDTH'(f_root), uz, uy, ux};
            out_zero_reg <= f_zero;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_zero_reg;

`ifndef SYNTHESIS
    // a stalled output freezes the whole pipe, so input must be held off
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // zero flag implies every field is zero
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero vector with nonzero fields");

    // a nonzero norm never yields a unit_x above one in magnitude
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            ($signed(m_axis_tdata[OUT_WIDTH-1:0]) <= 16384 &&
             $signed(m_axis_tdata[OUT_WIDTH-1:0]) >= -16384))
        else $error("unit_x out of range");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_vector_normalize_3d.sv
// Self-checking bench for the 3-D vector normalizer: norm and unit vector per beat.
`timescale 1ns / 1ps
`default_nettype none
module tb_vector_normalize_3d;
    import vnorm_pkg::*;

    localparam int RUN_ITEMS  = 1100;
    localparam int MAX_CYCLES = 400000;
    localparam int DRAIN_WAIT = 120;   // well over the pipe depth

    typedef struct packed {
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] uz;
        logic [15:0] mag;
        logic        zero;
    } norm_res_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 has_fixed;   // expected result typed in by hand
        norm_res_t          fixed;
    } vec_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // comp_x, comp_y, comp_z
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // unit_x, unit_y, unit_z, magnitude
    logic                    m_axis_tuser;   // zero_vector

    norm_res_t pending_norms[$];
    int        mismatches;
    int        beats_in;
    int        beats_out;
    int        zero_seen;
    int        cycles;
    bit        hold_off;     // long receiver stall, driven by its own process
    bit        stim_done;

    vector_normalize_3d u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor square root, bit by bit
    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] unit_comp(logic signed [15:0] c, logic [63:0] norm);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (c < 0) ? 64'(-64'(c)) : 64'(c);
        q = (mag << FRAC_SHIFT) / norm;
        if (c < 0)
            q = -q;
        return q[15:0];
    endfunction

    function automatic norm_res_t normalize(logic signed [15:0] x, logic signed [15:0] y,
                                            logic signed [15:0] z);
        norm_res_t   r;
        logic [63:0] sum;
        logic [63:0] norm;
        sum = 64'(x * 64'sd1 * x) + 64'(y * 64'sd1 * y) + 64'(z * 64'sd1 * z);
        r = '0;
        if (sum == 0)
        begin
            r.zero = 1'b1;
            return r;
        end
        norm  = floor_root(sum);
        r.ux  = unit_comp(x, norm);
        r.uy  = unit_comp(y, norm);
        r.uz  = unit_comp(z, norm);
        r.mag = norm[15:0];
        return r;
    endfunction

    // directed rows; fixed results only where obvious
    vec_row_t dir_rows[$];

    task automatic add_row(int x, int y, int z, bit fx = 0, norm_res_t r = '0);
        vec_row_t v;
        v.x = 16'(x); v.y = 16'(y); v.z = 16'(z); v.has_fixed = fx; v.fixed = r;
        dir_rows.push_back(v);
    endtask

    task automatic build_rows();
        add_row(0, 0, 0, 1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1});
        add_row(256, 0, 0, 1, '{16'd16384, 16'd0, 16'd0, 16'd256, 1'b0});
        add_row(0, 256, 0, 1, '{16'd0, 16'd16384, 16'd0, 16'd256, 1'b0});
        add_row(0, 0, -256, 1, '{16'd0, 16'd0, -16'sd16384, 16'd256, 1'b0});
        add_row(-32768, 0, 0, 1, '{-16'sd16384, 16'd0, 16'd0, 16'd32768, 1'b0});
        add_row(32767, 0, 0, 1, '{16'd16384, 16'd0, 16'd0, 16'd32767, 1'b0});
        add_row(1, 0, 0, 1, '{16'd16384, 16'd0, 16'd0, 16'd1, 1'b0});
        add_row(0, -1, 0, 1, '{16'd0, -16'sd16384, 16'd0, 16'd1, 1'b0});
        add_row(-32768, -32768, -32768);   // largest norm
        add_row(32767, 32767, 32767);
        add_row(32767, -32768, 32767);
        add_row(300, 400, 0);              // 2-D vector
        add_row(-3, 4, 0);
        add_row(1, 1, 1);
        add_row(-1, -1, -1);
        add_row(1, 2, 2);
        add_row(21845, -10922, 5461);
        add_row(0, 0, 1);
        add_row(-21846, 10921, -5462);
    endtask

    function automatic logic signed [15:0] rand_comp(int kind);
        case (kind)
            0: return 16'(int'($urandom_range(0, 8)) - 4);      // tiny, close to zero
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return 16'(int'($urandom_range(0, 511)) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_beat(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, norm_res_t exp_r);
        s_axis_tdata  <= {z, y, x};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_norms.push_back(exp_r);
        beats_in++;
    endtask

    // sender: directed rows, then bursts with random gaps; valid drops only between rows or bursts
    initial
    begin
        int burst;
        int k;
        int n;
        int kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        stim_done     = 0;
        build_rows();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
        begin
            norm_res_t e;
            e = normalize(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
            if (dir_rows[i].has_fixed)
                e = dir_rows[i].fixed;
            send_beat(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, e);
            if ($urandom_range(0, 3) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        n = 0;
        while (n < RUN_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && n < RUN_ITEMS; k++)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    x = 0; y = 0; z = 0;
                end
                else
                begin
                    x = rand_comp($urandom_range(0, 3));
                    y = rand_comp($urandom_range(0, 3));
                    z = (kind < 3) ? 16'sd0 : rand_comp($urandom_range(0, 3));
                end
                send_beat(x, y, z, normalize(x, y, z));
                n++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    // one long hold-off early in the random part so the pipe backs up
    initial
    begin
        hold_off = 0;
        wait (beats_in >= 60);
        @(posedge clk);
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
    end

    // receiver stall pattern: quiet, light and heavy phases
    initial
    begin
        int phase;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            phase = $urandom_range(0, 2);
            repeat ($urandom_range(20, 80))
            begin
                @(posedge clk);
                if (hold_off)
                    m_axis_tready <= 1'b0;
                else if (phase == 0)
                    m_axis_tready <= 1'b1;
                else if (phase == 1)
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                else
                    m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // checker: compare each output beat with the oldest expectation
    always @(posedge clk)
    begin
        norm_res_t got;
        norm_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tdata[63:48], m_axis_tuser};
            beats_out++;
            if (m_axis_tuser)
                zero_seen++;
            if (pending_norms.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output beat %h", got);
            end
            else
            begin
                want = pending_norms.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR beat %0d: exp ux=%h uy=%h uz=%h mag=%h z=%b,",
                                  " got ux=%h uy=%h uz=%h mag=%h z=%b"},
                                 beats_out, want.ux, want.uy, want.uz, want.mag,
                                 want.zero, got.ux, got.uy, got.uz, got.mag, got.zero);
                end
            end
        end
    end

    initial
    begin
        mismatches = 0;
        beats_in   = 0;
        beats_out  = 0;
        zero_seen  = 0;
        cycles     = 0;
    end

    // end of run: drain, settle, report; or time out
    initial
    begin
        bit timed_out;
        timed_out = 0;
        fork
            begin
                wait (stim_done && pending_norms.size() == 0);
                repeat (DRAIN_WAIT) @(posedge clk);
            end
            begin
                while (cycles < MAX_CYCLES)
                begin
                    @(posedge clk);
                    cycles++;
                end
                timed_out = 1;
            end
        join_any
        disable fork;
        $display("Sent %0d vectors, %0d results checked (%0d zero vectors),", beats_in,
                 beats_out, zero_seen);
        $display("including component extremes, 2-D vectors and a long output stall.");
        if (timed_out)
        begin
            $display("Timeout with %0d results outstanding", pending_norms.size());
            $display("FAIL");
        end
        else if (mismatches == 0 && pending_norms.size() == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/vnorm_pkg.sv
hw/rtl/vnorm_sqrt.sv
hw/rtl/vnorm_div.sv
hw/rtl/vector_normalize_3d.sv
bench/tb_vector_normalize_3d.sv
